// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, opcodes, status codes and the command type that passes
// from the front part to the back part of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int OPCODE_W      = 3;
    localparam int DATA_W        = 64;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BACK  = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t           op;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

// ===== sv/deq_if.sv =====
// ----------------------------------------------------------------------------
// Deque channels
// Valid/ready channels for requests into the deque and results out of it.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                        valid;
    logic                        ready;
    logic [deq_pkg::OPCODE_W-1:0] opcode;
    logic [deq_pkg::DATA_W-1:0]   data_value;

    modport source (output valid, output opcode, output data_value, input ready);
    modport sink   (input valid, input opcode, input data_value, output ready);
endinterface

interface deq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::DATA_W-1:0]   value;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic                         last;
    logic [deq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output value, output status, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input value, input status, input last,
                    input occupancy, output ready);
endinterface

// ===== sv/deq_front.sv =====
// ----------------------------------------------------------------------------
// Deque front end
// Accepts requests, drops unknown opcodes and holds up to two commands
// for the back end.
// ----------------------------------------------------------------------------
module deq_front (
    input  logic          clk,
    input  logic          rst_n,
    deq_req_if.sink       request,
    output logic          cmd_valid,
    output deq_pkg::cmd_t cmd,
    input  logic          cmd_ready
);
    import deq_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       known;
    logic       push;
    logic       pop;

    assign request.ready = (fill_reg != 2'd2);
    assign cmd_valid     = (fill_reg != 2'd0);
    assign cmd           = q_mem[rd_ptr_reg];

    always_comb
    begin
        known = request.opcode inside {[OP_PUSH_FRONT:OP_LIST_BACK]};
        push  = request.valid && request.ready && known;
        pop   = cmd_valid && cmd_ready;

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: opcode_t'(request.opcode), data: request.data_value};
        end
    end

endmodule

// ===== sv/deq_back.sv =====
// ----------------------------------------------------------------------------
// Deque back end
// Holds the ring store, head pointer and count, carries out each command
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  deq_pkg::cmd_t cmd,
    output logic          cmd_ready,
    deq_rsp_if.source     result
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST_ADDR,
        S_LIST_OUT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic                dir_back_reg;
    logic                dir_back_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   out_value_reg;
    logic [DATA_W-1:0]   out_value_next;
    status_t             out_status_reg;
    status_t             out_status_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic [CNT_W-1:0]    out_occ_reg;
    logic [CNT_W-1:0]    out_occ_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;

    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic [PTR_W-1:0]    head_dec;
    logic [PTR_W-1:0]    head_inc;
    logic [PTR_W-1:0]    tail_pos;
    logic [CNT_W-1:0]    count_m1;
    logic [CNT_W-1:0]    list_off;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    function automatic logic [PTR_W-1:0] ring_at(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign result.valid     = out_valid_reg;
    assign result.value     = out_value_reg;
    assign result.status    = out_status_reg;
    assign result.last      = out_last_reg;
    assign occ_ext          = {{OCC_W{1'b0}}, out_occ_reg};
    assign result.occupancy = occ_ext[OCC_W-1:0];

    always_comb
    begin
        out_free = !out_valid_reg || result.ready;
        is_full  = (count_reg == CNT_W'(DEPTH));
        is_empty = (count_reg == '0);
        head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
        head_inc = ring_at(head_reg, PTR_W'(1));
        tail_pos = ring_at(head_reg, count_reg[PTR_W-1:0]);
        count_m1 = count_reg - CNT_W'(1);
        list_off = dir_back_reg ? (count_m1 - idx_reg) : idx_reg;
        rd_addr  = ring_at(head_reg, list_off[PTR_W-1:0]);

        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        dir_back_next   = dir_back_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;
        cmd_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = tail_pos;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    head_next = head_dec;
                                    wr_addr   = head_dec;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                                if (cmd.op == OP_POP_FRONT)
                                begin
                                    head_next = head_inc;
                                end
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // The walk emits its own results; nothing is loaded now.
                                out_valid_next = out_valid_reg && !result.ready;
                                out_value_next = out_value_reg;
                                out_last_next  = out_last_reg;
                                out_status_next = out_status_reg;
                                dir_back_next  = (cmd.op == OP_LIST_BACK);
                                idx_next       = '0;
                                state_next     = S_LIST_ADDR;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !result.ready;
                        end
                    endcase
                    out_occ_next = count_next;
                end
            end
            S_LIST_ADDR:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_data_reg;
                    out_status_next = ST_OK;
                    out_last_next   = (idx_reg == count_m1);
                    out_occ_next    = count_reg;
                    if (idx_reg == count_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_LIST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            dir_back_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            dir_back_reg   <= dir_back_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} < (PTR_W+1)'(DEPTH))
        else $error("head pointer outside the ring");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && cmd_ready && is_full &&
         (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK))
        |=> (out_valid_reg && out_status_reg == ST_FULL &&
             $stable(count_reg) && $stable(head_reg)))
        else $error("push into a full deque changed the state");

    a_list_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST_ADDR || state_reg == S_LIST_OUT)
        |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("deque state changed during a listing");

endmodule

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of 64-bit words with push, pop and listing at both ends.
// ----------------------------------------------------------------------------
// Requests arrive on the request channel with an opcode and a data word;
// results leave on the result channel, each with a value, a status, a last
// flag and the occupancy after the operation. Unknown opcodes are taken and
// produce no result.
// A front end takes requests into a two-entry command queue; the back end
// executes them against the ring store. A push or pop presents its single
// result from the result register once the back end has taken its command
// from the queue; pushes and pops run at one request per cycle while results
// are taken.
// A listing reads the ring store through its registered read port, with an
// address state and an output state per entry, and holds the back end until
// its last entry leaves; requests keep queuing in the front end meanwhile.
// Reset empties the deque; the store contents are undefined until written.
// When the receiver stalls, the result register holds, the back end waits,
// and the request channel stalls once the command queue is full.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   request,
    deq_rsp_if.source result
);
    import deq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .result    (result)
    );

endmodule
